>>> design/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W = 16;
    localparam int ERR_W  = DATA_W + 1;            // setpoint - measured
    localparam int DIFF_W = ERR_W + 1;             // error - previous error
    localparam int PROD_W = DATA_W + DIFF_W;       // gain times error or difference

    // Default fraction bits of the gains and of the integral.
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Reset value of the upper limit.
    localparam logic [DATA_W-1:0] HIGH_LIMIT_RST = 16'd255;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_LOW_LIMIT  = 3'd3,
        REG_HIGH_LIMIT = 3'd4
    } reg_idx_t;

    // Divider: the magnitude of the derivative numerator stays below 2^32,
    // and the unit retires two quotient bits per step.
    localparam int DIV_W         = 32;
    localparam int DIV_BITS_STEP = 2;
    localparam int DIV_STEPS     = DIV_W / DIV_BITS_STEP;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    // Micro-operations carried out by the datapath.
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_RELOAD,
        UOP_MUL_KI,
        UOP_INTEG,
        UOP_MUL_KD,
        UOP_DIV_START,
        UOP_DIV_STEP,
        UOP_DIV_END,
        UOP_MUL_KP,
        UOP_SUM,
        UOP_FINISH
    } uop_t;

    // What a step waits for before it executes.
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    // How the step counter moves once a step executes.
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_DIV_LOOP,
        JMP_ABS
    } jump_t;

    localparam int PROG_LEN = 11;
    localparam int STEP_W   = $clog2(PROG_LEN);

    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DIV  = 4'd6;

    typedef struct packed {
        uop_t              op;
        hold_t             hold;
        jump_t             jump;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // Control handed from the sequencer to the datapath and the divider.
    typedef struct packed {
        uop_t op;
        logic exec;
        logic in_ready;
    } pcc_ctrl_t;

    // Conditions the sequencer branches and waits on.
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic div_last;
    } pcc_status_t;

    // The microprogram for one word.
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = '{op: UOP_NOP, hold: HOLD_NONE, jump: JMP_ABS, target: STEP_IDLE};
        case (step)
            4'd0:  cw = '{op: UOP_LOAD,      hold: HOLD_IN,   jump: JMP_NEXT,     target: STEP_IDLE};
            4'd1:  cw = '{op: UOP_RELOAD,    hold: HOLD_NONE, jump: JMP_NEXT,     target: STEP_IDLE};
            4'd2:  cw = '{op: UOP_MUL_KI,    hold: HOLD_NONE, jump: JMP_NEXT,     target: STEP_IDLE};
            4'd3:  cw = '{op: UOP_INTEG,     hold: HOLD_NONE, jump: JMP_NEXT,     target: STEP_IDLE};
            4'd4:  cw = '{op: UOP_MUL_KD,    hold: HOLD_NONE, jump: JMP_NEXT,     target: STEP_IDLE};
            4'd5:  cw = '{op: UOP_DIV_START, hold: HOLD_NONE, jump: JMP_NEXT,     target: STEP_IDLE};
            4'd6:  cw = '{op: UOP_DIV_STEP,  hold: HOLD_NONE, jump: JMP_DIV_LOOP, target: STEP_DIV};
            4'd7:  cw = '{op: UOP_DIV_END,   hold: HOLD_NONE, jump: JMP_NEXT,     target: STEP_IDLE};
            4'd8:  cw = '{op: UOP_MUL_KP,    hold: HOLD_NONE, jump: JMP_NEXT,     target: STEP_IDLE};
            4'd9:  cw = '{op: UOP_SUM,       hold: HOLD_NONE, jump: JMP_NEXT,     target: STEP_IDLE};
            4'd10: cw = '{op: UOP_FINISH,    hold: HOLD_OUT,  jump: JMP_ABS,      target: STEP_IDLE};
            default: cw = '{op: UOP_NOP, hold: HOLD_NONE, jump: JMP_ABS, target: STEP_IDLE};
        endcase
        return cw;
    endfunction

endpackage

>>> design/pcc_sequencer.sv
`timescale 1ns / 1ps

module pcc_sequencer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pcc_pkg::pcc_status_t  status,
    output pcc_pkg::pcc_ctrl_t    ctrl
);

    logic [pcc_pkg::STEP_W-1:0] step_reg;
    logic [pcc_pkg::STEP_W-1:0] step_next;
    pcc_pkg::ctrl_word_t        cw;
    logic                       go;

    assign cw = pcc_pkg::ucode(step_reg);

    always_comb begin
        case (cw.hold)
            pcc_pkg::HOLD_NONE: go = 1'b1;
            pcc_pkg::HOLD_IN:   go = status.in_valid;
            pcc_pkg::HOLD_OUT:  go = status.out_free;
            default:            go = 1'b1;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (go) begin
            case (cw.jump)
                pcc_pkg::JMP_NEXT:     step_next = step_reg + pcc_pkg::STEP_W'(1);
                pcc_pkg::JMP_DIV_LOOP: step_next = status.div_last
                                                 ? step_reg + pcc_pkg::STEP_W'(1)
                                                 : cw.target;
                pcc_pkg::JMP_ABS:      step_next = cw.target;
                default:               step_next = pcc_pkg::STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= pcc_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    assign ctrl.op       = cw.op;
    assign ctrl.exec     = go;
    assign ctrl.in_ready = (cw.hold == pcc_pkg::HOLD_IN);

endmodule

>>> design/pcc_divider.sv
`timescale 1ns / 1ps

module pcc_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pcc_pkg::pcc_ctrl_t          ctrl,
    input  logic [pcc_pkg::DIV_W-1:0]   num,
    input  logic [pcc_pkg::DATA_W-1:0]  den,
    output logic [pcc_pkg::DIV_W-1:0]   quot,
    output logic                        last
);

    // Restoring division: the numerator register shifts out dividend bits
    // at the top and takes quotient bits in at the bottom.
    logic [pcc_pkg::DIV_W-1:0]     num_reg;
    logic [pcc_pkg::DATA_W-1:0]    rem_reg;
    logic [pcc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [pcc_pkg::DIV_W-1:0]     num_next;
    logic [pcc_pkg::DATA_W-1:0]    rem_next;

    always_comb begin
        logic [pcc_pkg::DATA_W:0] trial;
        num_next = num_reg;
        rem_next = rem_reg;
        for (int i = 0; i < pcc_pkg::DIV_BITS_STEP; i++) begin
            trial    = {rem_next, num_next[pcc_pkg::DIV_W-1]};
            num_next = {num_next[pcc_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, den}) begin
                trial       = trial - {1'b0, den};
                num_next[0] = 1'b1;
            end
            rem_next = trial[pcc_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctrl.exec && ctrl.op == pcc_pkg::UOP_DIV_START) begin
            cnt_reg <= '0;
        end else if (ctrl.exec && ctrl.op == pcc_pkg::UOP_DIV_STEP) begin
            cnt_reg <= cnt_reg + pcc_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.exec && ctrl.op == pcc_pkg::UOP_DIV_START) begin
            num_reg <= num;
            rem_reg <= '0;
        end else if (ctrl.exec && ctrl.op == pcc_pkg::UOP_DIV_STEP) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quot = num_reg;
    assign last = (cnt_reg == pcc_pkg::DIV_CNT_W'(pcc_pkg::DIV_STEPS - 1));

endmodule

>>> design/pcc_datapath.sv
`timescale 1ns / 1ps

module pcc_datapath #(
    parameter int GAIN_FRAC_BITS = pcc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pcc_pkg::pcc_ctrl_t             ctrl,
    input  logic                           cfg_wr_en,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcc_pkg::DATA_W-1:0]     cfg_wdata,
    input  logic signed [pcc_pkg::DATA_W-1:0] s_measured,
    input  logic signed [pcc_pkg::DATA_W-1:0] s_setpoint,
    input  logic [pcc_pkg::DATA_W-1:0]     s_elapsed_ticks,
    input  logic                           s_enable,
    input  logic                           m_ready,
    input  logic [pcc_pkg::DIV_W-1:0]      div_quot,
    output logic [pcc_pkg::DIV_W-1:0]      div_num,
    output logic [pcc_pkg::DATA_W-1:0]     div_den,
    output logic                           out_free,
    output logic                           m_valid,
    output logic signed [pcc_pkg::DATA_W-1:0] m_drive,
    output logic                           m_clamped,
    output logic                           m_zero_time
);

    localparam int DW     = pcc_pkg::DATA_W;
    localparam int INT_W  = DW + GAIN_FRAC_BITS;
    localparam int ACC_W  = ((INT_W > pcc_pkg::PROD_W) ? INT_W : pcc_pkg::PROD_W) + 2;
    localparam int PROD_W = pcc_pkg::PROD_W;
    localparam int ERR_W  = pcc_pkg::ERR_W;
    localparam int DIFF_W = pcc_pkg::DIFF_W;

    // High limit first, then low limit; the top bit reports a hit.
    function automatic logic [ACC_W:0] clamp_q(input logic signed [ACC_W-1:0] v,
                                               input logic signed [ACC_W-1:0] hi,
                                               input logic signed [ACC_W-1:0] lo);
        logic signed [ACC_W-1:0] r;
        logic                    h;
        r = v;
        h = 1'b0;
        if (r > hi) begin
            r = hi;
            h = 1'b1;
        end
        if (r < lo) begin
            r = lo;
            h = 1'b1;
        end
        return {h, r};
    endfunction

    logic signed [DW-1:0]     prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic signed [DW-1:0]     low_limit_reg, high_limit_reg;
    logic signed [INT_W-1:0]  integ_reg;
    logic signed [ERR_W-1:0]  last_err_reg;
    logic signed [DW-1:0]     last_drive_reg;
    logic                     was_en_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic [DW-1:0]            ticks_reg;
    logic                     en_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic signed [PROD_W-1:0] deriv_reg;
    logic signed [ACC_W-1:0]  sum_reg;
    logic                     m_valid_reg;
    logic signed [DW-1:0]     m_drive_reg;
    logic                     m_clamped_reg;
    logic                     m_zero_time_reg;

    logic signed [ACC_W-1:0]  hi_q, lo_q;
    logic signed [ACC_W-1:0]  reload_in, integ_in, sum_in;
    logic [ACC_W:0]           reload_res, integ_res, final_res;
    logic signed [ACC_W-1:0]  final_val;
    logic signed [DW-1:0]     drive_val;
    logic signed [DW-1:0]     mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] quot_ext;
    logic signed [PROD_W-1:0] deriv_val;
    logic [PROD_W-1:0]        prod_mag;
    logic                     rising;
    logic                     ticks_zero;

    assign rising     = en_reg & ~was_en_reg;
    assign ticks_zero = (ticks_reg == '0);

    assign hi_q = ACC_W'(high_limit_reg) <<< GAIN_FRAC_BITS;
    assign lo_q = ACC_W'(low_limit_reg) <<< GAIN_FRAC_BITS;

    assign reload_in  = ACC_W'(last_drive_reg) <<< GAIN_FRAC_BITS;
    assign reload_res = clamp_q(reload_in, hi_q, lo_q);
    assign integ_in   = ACC_W'(integ_reg) + ACC_W'(prod_reg);
    assign integ_res  = clamp_q(integ_in, hi_q, lo_q);
    assign sum_in     = ACC_W'(prod_reg) + ACC_W'(integ_reg) + ACC_W'(deriv_reg);
    assign final_res  = clamp_q(sum_reg, hi_q, lo_q);
    assign final_val  = $signed(final_res[ACC_W-1:0]);
    assign drive_val  = DW'(final_val >>> GAIN_FRAC_BITS);

    // One shared multiplier; the operands follow the micro-operation.
    always_comb begin
        case (ctrl.op)
            pcc_pkg::UOP_MUL_KI: begin
                mul_a = integ_gain_reg;
                mul_b = DIFF_W'(err_reg);
            end
            pcc_pkg::UOP_MUL_KD: begin
                mul_a = deriv_gain_reg;
                mul_b = diff_reg;
            end
            default: begin
                mul_a = prop_gain_reg;
                mul_b = DIFF_W'(err_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign div_num  = prod_mag[pcc_pkg::DIV_W-1:0];
    assign div_den  = ticks_reg;
    assign quot_ext = $signed(PROD_W'(div_quot));
    assign deriv_val = ticks_zero ? '0 : (neg_reg ? -quot_ext : quot_ext);

    assign out_free = ~m_valid_reg | m_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            low_limit_reg  <= '0;
            high_limit_reg <= pcc_pkg::HIGH_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pcc_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata;
                pcc_pkg::REG_INTEG_GAIN: integ_gain_reg <= cfg_wdata;
                pcc_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg_wdata;
                pcc_pkg::REG_LOW_LIMIT:  low_limit_reg  <= cfg_wdata;
                pcc_pkg::REG_HIGH_LIMIT: high_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Controller state and the output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg      <= '0;
            last_err_reg   <= '0;
            last_drive_reg <= '0;
            was_en_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (ctrl.exec) begin
                case (ctrl.op)
                    pcc_pkg::UOP_RELOAD: begin
                        if (rising) begin
                            integ_reg <= INT_W'($signed(reload_res[ACC_W-1:0]));
                        end
                    end
                    pcc_pkg::UOP_INTEG: begin
                        integ_reg <= INT_W'($signed(integ_res[ACC_W-1:0]));
                    end
                    pcc_pkg::UOP_FINISH: begin
                        last_err_reg   <= err_reg;
                        last_drive_reg <= drive_val;
                        was_en_reg     <= en_reg;
                        m_valid_reg    <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Working registers and the output word.
    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            case (ctrl.op)
                pcc_pkg::UOP_LOAD: begin
                    err_reg   <= ERR_W'(s_setpoint) - ERR_W'(s_measured);
                    ticks_reg <= s_elapsed_ticks;
                    en_reg    <= s_enable;
                end
                pcc_pkg::UOP_RELOAD: begin
                    // A rising enable clears the previous error.
                    diff_reg <= rising ? DIFF_W'(err_reg)
                                       : DIFF_W'(err_reg) - DIFF_W'(last_err_reg);
                end
                pcc_pkg::UOP_MUL_KI,
                pcc_pkg::UOP_MUL_KD,
                pcc_pkg::UOP_MUL_KP: begin
                    prod_reg <= mul_p;
                end
                pcc_pkg::UOP_DIV_START: begin
                    neg_reg <= prod_reg[PROD_W-1];
                end
                pcc_pkg::UOP_DIV_END: begin
                    deriv_reg <= deriv_val;
                end
                pcc_pkg::UOP_SUM: begin
                    sum_reg <= sum_in;
                end
                pcc_pkg::UOP_FINISH: begin
                    m_drive_reg     <= drive_val;
                    m_clamped_reg   <= final_res[ACC_W];
                    m_zero_time_reg <= ticks_zero;
                end
                default: ;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_drive     = m_drive_reg;
    assign m_clamped   = m_clamped_reg;
    assign m_zero_time = m_zero_time_reg;

endmodule

>>> design/pid_controller_clamped_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------------
// input    | s_valid / s_ready  | s_measured, s_setpoint, s_elapsed_ticks, s_enable
// result   | m_valid / m_ready  | m_drive, m_clamped, m_zero_time
// config   | cfg_wr_en          | cfg_index, cfg_wdata
//
// One word is worked on at a time. After a word is accepted the result is ready
// once nine microcode steps after the load and sixteen passes of the divider that
// forms the derivative, two quotient bits per pass, are done. A new word is
// accepted in the cycle after the result is written. Reset is synchronous and
// active low; it loads the register reset values and clears the controller state,
// with no clearing pass. A stalled result holds only the final step; the next word
// may be accepted while a result waits.

module pid_controller_clamped_top #(
    parameter int GAIN_FRAC_BITS = pcc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcc_pkg::DATA_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [pcc_pkg::DATA_W-1:0] s_measured,
    input  logic signed [pcc_pkg::DATA_W-1:0] s_setpoint,
    input  logic [pcc_pkg::DATA_W-1:0]        s_elapsed_ticks,
    input  logic                              s_enable,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pcc_pkg::DATA_W-1:0] m_drive,
    output logic                              m_clamped,
    output logic                              m_zero_time
);

    pcc_pkg::pcc_ctrl_t   ctrl;
    pcc_pkg::pcc_status_t status;
    logic [pcc_pkg::DIV_W-1:0]  div_num;
    logic [pcc_pkg::DIV_W-1:0]  div_quot;
    logic [pcc_pkg::DATA_W-1:0] div_den;
    logic                       div_last;
    logic                       out_free;

    // The sequencer waits on the input word in its first step and on a free
    // output register in its last; the divider loop ends on the divider's count.
    assign status.in_valid = s_valid;
    assign status.out_free = out_free;
    assign status.div_last = div_last;

    assign s_ready = ctrl.in_ready;

    pcc_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    pcc_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_measured      (s_measured),
        .s_setpoint      (s_setpoint),
        .s_elapsed_ticks (s_elapsed_ticks),
        .s_enable        (s_enable),
        .m_ready         (m_ready),
        .div_quot        (div_quot),
        .div_num         (div_num),
        .div_den         (div_den),
        .out_free        (out_free),
        .m_valid         (m_valid),
        .m_drive         (m_drive),
        .m_clamped       (m_clamped),
        .m_zero_time     (m_zero_time)
    );

    // The derivative quotient is formed on magnitudes; the datapath restores
    // the sign, which truncates toward zero.
    pcc_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .last    (div_last)
    );

endmodule

>>> design/pcc_checker.sv
`timescale 1ns / 1ps

module pcc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [pcc_pkg::DATA_W-1:0] m_drive,
    input logic                              m_clamped,
    input logic                              m_zero_time
);

    // A waiting result keeps its word.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive) && $stable(m_clamped)
                                && $stable(m_zero_time))
        else $error("result word changed or dropped while stalled");

    // Only one word is in work: acceptance closes the input at once.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again while a word is in work");

    // A result appears only at the end of a word's work.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while the sequencer was idle");

    // A freshly accepted word cannot produce a result in the next cycle.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared right after acceptance");

endmodule

bind pid_controller_clamped_top pcc_checker u_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pcc_pkg::*;

    // The controller runs with the default number of fraction bits.  The
    // expected values below use the same scaling.
    localparam int FRAC = GAIN_FRAC_BITS_DEF;

    // An index that maps to no register.  A write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // How the result side stalls during a stretch of cycles.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_CHOPPY,
        RX_LONG_STALLS
    } rx_mode_t;

    // One controller result as it appears on the result channel.
    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     clamped;
        logic                     zero_time;
    } drive_word_t;

    // Keeps its own copy of the gains, limits and loop state, and works out
    // the drive for each accepted word.  Results are compared in order.
    class pid_scoreboard;
        longint      kp, ki, kd, lo_lim, hi_lim;
        longint      integ_acc, prev_err, prev_drive;
        bit          was_on;
        drive_word_t pending[$];
        int          errors;

        function new();
            errors = 0;
            reset_state();
        endfunction

        function void reset_state();
            kp         = 0;
            ki         = 0;
            kd         = 0;
            lo_lim     = 0;
            hi_lim     = longint'($signed(HIGH_LIMIT_RST));
            integ_acc  = 0;
            prev_err   = 0;
            prev_drive = 0;
            was_on     = 1'b0;
            pending.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            longint v;
            v = longint'($signed(val));
            case (idx)
                REG_PROP_GAIN:  kp = v;
                REG_INTEG_GAIN: ki = v;
                REG_DERIV_GAIN: kd = v;
                REG_LOW_LIMIT:  lo_lim = v;
                REG_HIGH_LIMIT: hi_lim = v;
                default: ;
            endcase
        endfunction

        // High limit first, then low, so an inverted pair yields the low limit.
        function longint clamp_scaled(longint v, output bit hit);
            longint hi, lo;
            hi  = hi_lim <<< FRAC;
            lo  = lo_lim <<< FRAC;
            hit = 1'b0;
            if (v > hi) begin
                v   = hi;
                hit = 1'b1;
            end
            if (v < lo) begin
                v   = lo;
                hit = 1'b1;
            end
            return v;
        endfunction

        function void note_word(logic signed [DATA_W-1:0] meas,
                                logic signed [DATA_W-1:0] setp,
                                logic [DATA_W-1:0] ticks, logic en);
            longint      err, deriv, total;
            bit          hit, unused_hit;
            drive_word_t res;
            if (en && !was_on) begin
                integ_acc = clamp_scaled(prev_drive <<< FRAC, unused_hit);
                prev_err  = 0;
            end
            err       = longint'(setp) - longint'(meas);
            integ_acc = clamp_scaled(integ_acc + ki * err, unused_hit);
            if (ticks == '0) begin
                deriv         = 0;
                res.zero_time = 1'b1;
            end else begin
                // Signed division truncates toward zero.
                deriv         = (kd * (err - prev_err)) / longint'(ticks);
                res.zero_time = 1'b0;
            end
            total       = clamp_scaled(kp * err + integ_acc + deriv, hit);
            total       = total >>> FRAC;
            res.drive   = total[DATA_W-1:0];
            res.clamped = hit;
            prev_err    = err;
            prev_drive  = total;
            was_on      = en;
            pending.push_back(res);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 30)
                $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        task check_result(drive_word_t got);
            drive_word_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result drive=%0d", got.drive));
            end else begin
                want = pending.pop_front();
                if (got.drive !== want.drive)
                    report_mismatch($sformatf("drive %0d, expected %0d",
                                              got.drive, want.drive));
                if (got.clamped !== want.clamped)
                    report_mismatch($sformatf("clamped %0b, expected %0b",
                                              got.clamped, want.clamped));
                if (got.zero_time !== want.zero_time)
                    report_mismatch($sformatf("zero_time %0b, expected %0b",
                                              got.zero_time, want.zero_time));
            end
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_measured;
    logic signed [DATA_W-1:0] s_setpoint;
    logic [DATA_W-1:0]        s_elapsed_ticks;
    logic                     s_enable;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_drive;
    logic                     m_clamped;
    logic                     m_zero_time;

    pid_scoreboard board;

    // Enable level carried from one random word to the next, so that words
    // come in runs with the loop on or off, and rising edges happen now and then.
    logic     en_level;
    rx_mode_t rx_mode;
    int       rx_cycles;
    int       stall_left;

    pid_controller_clamped_top #(
        .GAIN_FRAC_BITS(FRAC)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_measured     (s_measured),
        .s_setpoint     (s_setpoint),
        .s_elapsed_ticks(s_elapsed_ticks),
        .s_enable       (s_enable),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive        (m_drive),
        .m_clamped      (m_clamped),
        .m_zero_time    (m_zero_time)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Result side.  A word is taken at an edge where m_valid and m_ready were
    // both high just before it.  The ready pattern switches at random between
    // modes: always ready, ready at random with odds of three in four, or mostly
    // ready with occasional stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            rx_mode    = RX_STEADY;
            rx_cycles  = 0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready)
                board.check_result('{drive: m_drive, clamped: m_clamped,
                                     zero_time: m_zero_time});
            rx_cycles++;
            if (rx_cycles % 700 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 2));
            case (rx_mode)
                RX_STEADY: m_ready <= 1'b1;
                RX_CHOPPY: m_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 9) == 0)
                            stall_left = $urandom_range(5, 40);
                    end
                end
            endcase
        end
    end

    // Offers one word and returns at the edge where it is accepted.  The
    // valid stays high; the caller lowers it only when a gap follows.
    task send_word(input logic [DATA_W-1:0] meas, input logic [DATA_W-1:0] setp,
                   input logic [DATA_W-1:0] ticks, input logic en);
        s_valid         <= 1'b1;
        s_measured      <= meas;
        s_setpoint      <= setp;
        s_elapsed_ticks <= ticks;
        s_enable        <= en;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_word(meas, setp, ticks, en);
    endtask

    // Stops sending and waits until every expected result has come back.
    // Each word gives exactly one result, so the block is idle after that.
    task wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Raises the write enable and writes one register.  The caller
    // lowers it once all writes of a setting are done.
    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.write_reg(idx, val);
    endtask

    task apply_settings(input logic [DATA_W-1:0] p_gain, input logic [DATA_W-1:0] i_gain,
                        input logic [DATA_W-1:0] d_gain, input logic [DATA_W-1:0] lo,
                        input logic [DATA_W-1:0] hi, input bit poke_spare);
        write_reg(REG_PROP_GAIN,  p_gain);
        write_reg(REG_INTEG_GAIN, i_gain);
        write_reg(REG_DERIV_GAIN, d_gain);
        write_reg(REG_LOW_LIMIT,  lo);
        write_reg(REG_HIGH_LIMIT, hi);
        if (poke_spare)
            write_reg(REG_SPARE, 16'h7FFF);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly modest setpoints with the measurement close by, so that the loop
    // spends time away from the limits; now and then full-range values, zero
    // elapsed time, very long elapsed times and enable toggles.
    task pick_word(output logic [DATA_W-1:0] meas, output logic [DATA_W-1:0] setp,
                   output logic [DATA_W-1:0] ticks, output logic en);
        int r;
        if ($urandom_range(0, 3) == 0)
            setp = 16'($urandom);
        else
            setp = 16'($urandom_range(0, 4000)) - 16'd2000;
        r = $urandom_range(0, 9);
        if (r < 2)
            meas = 16'($urandom);
        else if (r == 2)
            meas = setp;
        else
            meas = setp + 16'($urandom_range(0, 400)) - 16'd200;
        r = $urandom_range(0, 19);
        if (r < 2)
            ticks = '0;
        else if (r < 4)
            ticks = 16'($urandom);
        else
            ticks = 16'($urandom_range(1, 16));
        if ($urandom_range(0, 15) == 0)
            en_level = ~en_level;
        en = en_level;
    endtask

    // One setting of the registers followed by random words.  The sender
    // works in bursts with gaps between them; some bursts are long, and some
    // follow the one before with no gap.  Halfway through, the sender holds
    // off until the block has returned every result.
    task run_phase(input logic [DATA_W-1:0] p_gain, input logic [DATA_W-1:0] i_gain,
                   input logic [DATA_W-1:0] d_gain, input logic [DATA_W-1:0] lo,
                   input logic [DATA_W-1:0] hi, input bit poke_spare, input int count);
        int               burst_left;
        int               gap;
        logic [DATA_W-1:0] meas, setp, ticks;
        logic             en;
        wait_drained();
        apply_settings(p_gain, i_gain, d_gain, lo, hi, poke_spare);
        burst_left = 0;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                wait_drained();
                burst_left = 0;
            end
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 8);
            end
            pick_word(meas, setp, ticks, en);
            send_word(meas, setp, ticks, en);
            burst_left--;
        end
    endtask

    // Stimulus.  First two words with the reset values of the registers, then
    // a short directed list, then a sequence of register settings that include
    // the extreme gains, the widest limits, equal limits and a low limit above
    // the high limit.
    initial begin
        board           = new();
        en_level        = 1'b1;
        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= REG_PROP_GAIN;
        cfg_wdata       <= '0;
        s_valid         <= 1'b0;
        s_measured      <= '0;
        s_setpoint      <= '0;
        s_elapsed_ticks <= '0;
        s_enable        <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset register values: all gains zero, limits 0 and 255.
        send_word(16'd0, 16'd0, 16'd1, 1'b0);
        send_word(16'd100, 16'd50, 16'd0, 1'b1);

        wait_drained();
        apply_settings(16'd256, 16'd32, 16'd512, -16'sd2000, 16'sd2000, 1'b0);
        send_word(16'd0, 16'd10, 16'd1, 1'b0);              // inactive loop
        send_word(16'd0, 16'd20, 16'd1, 1'b1);              // enable rises: reload
        send_word(16'd0, 16'd20, 16'd0, 1'b1);              // zero elapsed time
        send_word(16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);      // largest positive error
        send_word(16'h7FFF, 16'h8000, 16'd1, 1'b1);         // largest negative error
        send_word(16'd5, 16'd5, 16'd3, 1'b1);
        send_word(16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1);
        send_word(16'h8000, 16'h8000, 16'd0, 1'b1);
        send_word(16'd0, 16'd1500, 16'd2, 1'b1);            // drives into the limit
        send_word(16'd0, 16'd1500, 16'd2, 1'b0);            // enable drops
        send_word(16'd0, 16'd1500, 16'd2, 1'b1);            // rises from a clamped drive
        send_word(-16'sd1, 16'd0, 16'd7, 1'b1);
        send_word(16'd1, 16'd0, 16'd7, 1'b1);
        send_word(-16'sd300, 16'd300, 16'd100, 1'b0);
        send_word(16'd100, 16'd0, 16'h8000, 1'b1);

        run_phase(16'($urandom_range(0, 1024)) - 16'd512,
                  16'($urandom_range(0, 64)) - 16'd32,
                  16'($urandom_range(0, 1024)) - 16'd512,
                  16'h8000, 16'h7FFF, 1'b1, 190);
        run_phase(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 190);
        run_phase(16'h8000, 16'h7FFF, 16'h8000, -16'sd100, 16'sd100, 1'b0, 190);
        // Low limit above the high limit: everything settles on the low limit.
        run_phase(16'($urandom), 16'($urandom), 16'($urandom),
                  16'sd500, -16'sd500, 1'b0, 190);
        run_phase(16'($urandom_range(0, 512)), 16'($urandom_range(0, 16)),
                  16'($urandom_range(0, 256)), 16'sd1234, 16'sd1234, 1'b0, 190);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 1'b0, 190);
        run_phase(16'($urandom_range(0, 600)) - 16'd300,
                  16'($urandom_range(0, 40)) - 16'd20,
                  16'($urandom_range(0, 4000)) - 16'd2000,
                  -16'sd20000, 16'sd20000, 1'b1, 190);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Guard against a hung handshake: a timeout several times the slowest
    // correct run.
    initial begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
